FILE: design/cpd_pkg.sv
// Shared constants and types for the checksummed packet deframer.
package cpd_pkg;

  // Frame store depth: length byte plus body bytes.
  localparam int FRAME_BYTES = 12;

  // Width of a frame position (0 .. FRAME_BYTES-1).
  localparam int LEN_W = $clog2(FRAME_BYTES);

  // Width of the byte_index output field.
  localparam int IDX_OUT_W = 4;

  localparam logic [7:0] PREAMBLE = 8'h3B;

  // Controller to datapath: chain shift strobe and output beat info.
  typedef struct packed {
    logic                 shift;
    logic                 out_valid;
    logic [IDX_OUT_W-1:0] index;
    logic                 last;
  } ctl_t;

endpackage

FILE: design/cpd_cell.sv
// One byte cell of the frame store chain.
module cpd_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d_in,
  output logic [7:0] q
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= d_in;
    end
  end

  assign q = data_r;

endmodule

FILE: design/cpd_ctrl.sv
// Frame parser, checksum tracking and replay sequencing.
module cpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [7:0]    in_tdata,
  output logic          in_tready,
  input  logic          out_tready,
  output cpd_pkg::ctl_t ctl
);

  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_BODY   = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_REPLAY = 3'd4;

  localparam int LW = cpd_pkg::LEN_W;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] skip_r, skip_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          in_acc;
  logic          shift;

  assign in_tready = (state_r != ST_REPLAY);
  assign in_acc    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    skip_nxt  = skip_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    shift     = 1'b0;
    case (state_r)
      ST_WAIT: begin
        if (in_acc && in_tdata == cpd_pkg::PREAMBLE) begin
          state_nxt = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        if (in_acc) begin
          if (in_tdata < 8'(cpd_pkg::FRAME_BYTES)) begin
            shift     = 1'b1;
            len_nxt   = LW'(in_tdata);
            rem_nxt   = LW'(in_tdata);
            sum_nxt   = in_tdata;
            state_nxt = (in_tdata == 8'd0) ? ST_CHECK : ST_BODY;
          end else begin
            // too long for the store: back to hunting
            len_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_BODY: begin
        if (in_acc) begin
          shift   = 1'b1;
          sum_nxt = sum_r + in_tdata;
          rem_nxt = rem_r - LW'(1);
          if (rem_r == LW'(1)) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          if (in_tdata == (8'h00 - sum_r)) begin
            // align byte 0 with the tap at the far end of the chain
            skip_nxt  = LW'(cpd_pkg::FRAME_BYTES - 1) - len_r;
            idx_nxt   = '0;
            state_nxt = ST_REPLAY;
          end else begin
            sum_nxt   = '0;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_REPLAY: begin
        if (skip_r != '0) begin
          shift    = 1'b1;
          skip_nxt = skip_r - LW'(1);
        end else if (out_tready) begin
          shift = 1'b1;
          if (idx_r == len_r) begin
            sum_nxt   = '0;
            state_nxt = ST_WAIT;
          end else begin
            idx_nxt = idx_r + LW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      len_r   <= '0;
      rem_r   <= '0;
      skip_r  <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      skip_r  <= skip_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign ctl.shift     = shift;
  assign ctl.out_valid = (state_r == ST_REPLAY) && (skip_r == '0);
  assign ctl.index     = cpd_pkg::IDX_OUT_W'(idx_r);
  assign ctl.last      = (idx_r == len_r);

endmodule

FILE: design/checksummed_packet_deframer.sv
// Top level of the checksummed packet deframer: controller plus byte cell chain.
//
//  channel | dir | tdata                              | tlast
//  in_     | in  | [7:0] rx_byte                      | -
//  out_    | out | [7:0] frame_byte, [11:8] byte_index | last_byte
//
// Input bytes are accepted whenever in_tvalid is high outside replay. A frame that
// passes its checksum is replayed: the cell chain moves one position per cycle unless
// an output beat stalls, first FRAME_BYTES-1-length alignment shifts, then one
// beat per stored byte from the tap at the last cell. No input is taken during
// replay. Reset clears control state only; the cells hold undefined data.
module checksummed_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [11:8] byte_index, [15:12] zero
  output logic        out_tlast   // last_byte
);

  localparam int N = cpd_pkg::FRAME_BYTES;

  cpd_pkg::ctl_t ctl;
  logic [7:0]    q [N];

  cpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      cpd_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d_in  (in_tdata),
        .q     (q[i])
      );
    end else begin : g_body
      cpd_cell u_cell (
        .clk   (clk),
        .shift (ctl.shift),
        .d_in  (q[i-1]),
        .q     (q[i])
      );
    end
  end

  assign out_tvalid = ctl.out_valid;
  assign out_tdata  = {4'd0, ctl.index, q[N-1]};
  assign out_tlast  = ctl.last;

endmodule

FILE: design/cpd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module cpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // input is closed while a frame is replayed
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during replay");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output beat changed");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("replay did not end after last beat");

  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && !in_tready)
    else $error("replay broke off before last beat");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind checksummed_packet_deframer cpd_checker u_cpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
